// File: src/crd_pkg.sv
package crd_pkg;

   // Byte classes produced by the front end
   localparam logic [1:0] KIND_LETTER = 2'd0;
   localparam logic [1:0] KIND_DIGIT  = 2'd1;
   localparam logic [1:0] KIND_DOLLAR = 2'd2;
   localparam logic [1:0] KIND_OTHER  = 2'd3;

   // Field and register widths
   localparam int CHAR_W   = 8;
   localparam int VALUE_W  = 5;
   localparam int COLUMN_W = 15;
   localparam int ROW_W    = 24;
   localparam int CSR_W    = 24;
   localparam int CSR_IDX_W = 1;

   // Widths that hold one multiply-add step before the limit compare
   localparam int COL_WIDE_W = COLUMN_W + 5;
   localparam int ROW_WIDE_W = ROW_W + 4;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_COLUMN = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ROW    = 1'b1;

   // Register reset values
   localparam logic [COLUMN_W-1:0] MAX_COLUMN_RESET = 15'd16384;
   localparam logic [ROW_W-1:0]    MAX_ROW_RESET    = 24'd1048576;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // One classified byte
   typedef struct packed {
      logic [1:0]         kind;
      logic [VALUE_W-1:0] value;
      logic               final_byte;
      logic               column_only;
   } byte_class_type;

endpackage

// File: src/crd_front.sv
module crd_front
   import crd_pkg::*;
(
   input  logic [CHAR_W-1:0] char_byte,
   input  logic              final_byte,
   input  logic              column_only,
   output byte_class_type    entry
);

   logic is_upper;
   logic is_lower;
   logic is_digit;

   // Character class decode
   assign is_upper = (char_byte >= 8'h41) && (char_byte <= 8'h5A);
   assign is_lower = (char_byte >= 8'h61) && (char_byte <= 8'h7A);
   assign is_digit = (char_byte >= 8'h30) && (char_byte <= 8'h39);

   // Class and value: letters map to 1..26, digits to 0..9
   always_comb begin
      entry.final_byte  = final_byte;
      entry.column_only = column_only;
      if (is_upper) begin
         entry.kind  = KIND_LETTER;
         entry.value = VALUE_W'(char_byte - 8'h40);
      end else if (is_lower) begin
         entry.kind  = KIND_LETTER;
         entry.value = VALUE_W'(char_byte - 8'h60);
      end else if (is_digit) begin
         entry.kind  = KIND_DIGIT;
         entry.value = VALUE_W'(char_byte - 8'h30);
      end else if (char_byte == 8'h24) begin
         entry.kind  = KIND_DOLLAR;
         entry.value = '0;
      end else begin
         entry.kind  = KIND_OTHER;
         entry.value = '0;
      end
   end

endmodule

// File: src/crd_queue.sv
module crd_queue
   import crd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  byte_class_type push_entry,
   output logic           full,
   input  logic           pop,
   output logic           head_valid,
   output byte_class_type head_entry
);

   byte_class_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]        wr_ptr_ff;
   logic [QPTR_W-1:0]        wr_ptr_in;
   logic [QPTR_W-1:0]        rd_ptr_ff;
   logic [QPTR_W-1:0]        rd_ptr_in;
   logic [QCNT_W-1:0]        count_ff;
   logic [QCNT_W-1:0]        count_in;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: src/crd_back.sv
module crd_back
   import crd_pkg::*;
#(
   parameter int MAX_LETTERS = 3,
   parameter int MAX_DIGITS  = 7
)(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  byte_class_type       head_entry,
   output logic                 pop,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_write_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_ref_valid,
   output logic [COLUMN_W-1:0]  rsp_column_index,
   output logic [ROW_W-1:0]     rsp_row_index,
   output logic                 rsp_column_absolute,
   output logic                 rsp_row_absolute
);

   localparam int LCW = $clog2(MAX_LETTERS + 1);
   localparam int DCW = $clog2(MAX_DIGITS + 1);

   localparam logic [2:0] PH_START      = 3'd0;
   localparam logic [2:0] PH_COL_DOLLAR = 3'd1;
   localparam logic [2:0] PH_LETTERS    = 3'd2;
   localparam logic [2:0] PH_ROW_DOLLAR = 3'd3;
   localparam logic [2:0] PH_DIGITS     = 3'd4;

   logic [COLUMN_W-1:0]   max_column_ff;
   logic [ROW_W-1:0]      max_row_ff;

   logic [2:0]            phase_ff, phase_in;
   logic                  mode_ff, mode_in;
   logic                  col_dollar_ff, col_dollar_in;
   logic                  row_dollar_ff, row_dollar_in;
   logic [LCW-1:0]        letter_count_ff, letter_count_in;
   logic [DCW-1:0]        digit_count_ff, digit_count_in;
   logic [COLUMN_W-1:0]   column_accum_ff, column_accum_in;
   logic [ROW_W-1:0]      row_accum_ff, row_accum_in;
   logic                  failed_ff, failed_in;

   logic [COL_WIDE_W-1:0] col_wide;
   logic [ROW_WIDE_W-1:0] row_wide;
   logic                  out_free;
   logic                  finish;
   logic                  result_ok;

   logic                  rsp_valid_ff;
   logic                  rsp_ref_valid_ff;
   logic [COLUMN_W-1:0]   rsp_column_ff;
   logic [ROW_W-1:0]      rsp_row_ff;
   logic                  rsp_col_abs_ff;
   logic                  rsp_row_abs_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_column_ff <= MAX_COLUMN_RESET;
         max_row_ff    <= MAX_ROW_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MAX_COLUMN: max_column_ff <= csr_write_data[COLUMN_W-1:0];
            CSR_MAX_ROW:    max_row_ff    <= csr_write_data[ROW_W-1:0];
            default: ;
         endcase
      end
   end

   // Only a last byte needs room in the output register
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop      = head_valid && (!head_entry.final_byte || out_free);
   assign finish   = pop && head_entry.final_byte;

   // One multiply-add per byte
   assign col_wide = COL_WIDE_W'(column_accum_ff) * COL_WIDE_W'(26)
                     + COL_WIDE_W'(head_entry.value);
   assign row_wide = ROW_WIDE_W'(row_accum_ff) * ROW_WIDE_W'(10)
                     + ROW_WIDE_W'(head_entry.value);

   // Parse state update
   always_comb begin
      phase_in        = phase_ff;
      col_dollar_in   = col_dollar_ff;
      row_dollar_in   = row_dollar_ff;
      letter_count_in = letter_count_ff;
      digit_count_in  = digit_count_ff;
      column_accum_in = column_accum_ff;
      row_accum_in    = row_accum_ff;
      failed_in       = failed_ff;

      // mode is taken from the first byte of a lexeme
      if (phase_ff == PH_START && letter_count_ff == '0 && !failed_ff) begin
         mode_in = head_entry.column_only;
      end else begin
         mode_in = mode_ff;
      end

      if (!failed_ff) begin
         unique case (head_entry.kind)
            KIND_LETTER: begin
               if (phase_ff > PH_LETTERS || letter_count_ff >= LCW'(MAX_LETTERS)) begin
                  failed_in = 1'b1;
               end else begin
                  letter_count_in = letter_count_ff + LCW'(1);
                  phase_in        = PH_LETTERS;
                  column_accum_in = col_wide[COLUMN_W-1:0];
                  if (col_wide > COL_WIDE_W'(max_column_ff)) begin
                     failed_in = 1'b1;
                  end
               end
            end
            KIND_DIGIT: begin
               if (mode_in || phase_ff < PH_LETTERS ||
                   digit_count_ff >= DCW'(MAX_DIGITS)) begin
                  failed_in = 1'b1;
               end else begin
                  digit_count_in = digit_count_ff + DCW'(1);
                  phase_in       = PH_DIGITS;
                  row_accum_in   = row_wide[ROW_W-1:0];
                  if (row_wide > ROW_WIDE_W'(max_row_ff)) begin
                     failed_in = 1'b1;
                  end
               end
            end
            KIND_DOLLAR: begin
               if (phase_ff == PH_START) begin
                  col_dollar_in = 1'b1;
                  phase_in      = PH_COL_DOLLAR;
               end else if (phase_ff == PH_LETTERS && !mode_in) begin
                  row_dollar_in = 1'b1;
                  phase_in      = PH_ROW_DOLLAR;
               end else begin
                  failed_in = 1'b1;
               end
            end
            KIND_OTHER: failed_in = 1'b1;
            default:    failed_in = 1'b1;
         endcase
      end
   end

   // Legal shape check at the last byte
   always_comb begin
      if (mode_in) begin
         result_ok = !failed_in && phase_in == PH_LETTERS;
      end else begin
         result_ok = !failed_in && phase_in == PH_DIGITS && row_accum_in != '0;
      end
   end

   // Parse state registers, cleared after each last byte
   always_ff @(posedge clock) begin
      if (reset || finish) begin
         phase_ff        <= PH_START;
         mode_ff         <= 1'b0;
         col_dollar_ff   <= 1'b0;
         row_dollar_ff   <= 1'b0;
         letter_count_ff <= '0;
         digit_count_ff  <= '0;
         column_accum_ff <= '0;
         row_accum_ff    <= '0;
         failed_ff       <= 1'b0;
      end else if (pop) begin
         phase_ff        <= phase_in;
         mode_ff         <= mode_in;
         col_dollar_ff   <= col_dollar_in;
         row_dollar_ff   <= row_dollar_in;
         letter_count_ff <= letter_count_in;
         digit_count_ff  <= digit_count_in;
         column_accum_ff <= column_accum_in;
         row_accum_ff    <= row_accum_in;
         failed_ff       <= failed_in;
      end
   end

   // Output register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Output register payload; invalid results read as zero
   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_ref_valid_ff <= result_ok;
         rsp_column_ff    <= result_ok ? column_accum_in - COLUMN_W'(1) : '0;
         rsp_row_ff       <= (result_ok && !mode_in) ? row_accum_in - ROW_W'(1) : '0;
         rsp_col_abs_ff   <= result_ok && col_dollar_in;
         rsp_row_abs_ff   <= result_ok && !mode_in && row_dollar_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_ref_valid       = rsp_ref_valid_ff;
   assign rsp_column_index    = rsp_column_ff;
   assign rsp_row_index       = rsp_row_ff;
   assign rsp_column_absolute = rsp_col_abs_ff;
   assign rsp_row_absolute    = rsp_row_abs_ff;

endmodule

// File: src/cell_reference_decoder.sv
// Cell reference decoder.
// The req_ channel takes one byte of a reference lexeme per transfer, with
// req_final_byte on its last byte; req_column_only is sampled on the first
// byte and selects letters-only mode. The rsp_ channel gives exactly one
// result per lexeme, on its last byte: validity, zero-based column and row,
// and the two absolute ($) flags. Invalid results carry zeros.
// Throughput: one byte per cycle, sustained unless a last byte waits on a
// stalled result, set by the combinational multiply-add and limit compare
// in the back end.
// A last byte is written into a queue slot, then parsed from the queue
// head straight into the output register, which drives rsp_valid.
// csr_ writes set max_column (index 0) and max_row (index 1); write them
// only while no lexeme is in flight.
// Reset clears the queue, the parse state and the output valid flag, and
// loads max_column = 16384 and max_row = 1048576.
// When rsp_stall holds, the result waits in the output register; bytes that
// are not last keep being parsed, a following last byte waits at the queue
// head, and req_stall rises once both queue entries are occupied.
module cell_reference_decoder
   import crd_pkg::*;
#(
   parameter int MAX_LETTERS = 3,
   parameter int MAX_DIGITS  = 7
)(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [CHAR_W-1:0]    req_char_byte,
   input  logic                 req_final_byte,
   input  logic                 req_column_only,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_write_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_ref_valid,
   output logic [COLUMN_W-1:0]  rsp_column_index,
   output logic [ROW_W-1:0]     rsp_row_index,
   output logic                 rsp_column_absolute,
   output logic                 rsp_row_absolute
);

   byte_class_type front_entry;
   byte_class_type head_entry;
   logic           queue_full;
   logic           head_valid;
   logic           pop;

   assign req_stall = queue_full;

   // Classify incoming bytes
   crd_front u_front (
      .char_byte   (req_char_byte),
      .final_byte  (req_final_byte),
      .column_only (req_column_only),
      .entry       (front_entry)
   );

   // Decouple front and back
   crd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_valid && !queue_full),
      .push_entry (front_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   // Parse state, limits and result register
   crd_back #(
      .MAX_LETTERS (MAX_LETTERS),
      .MAX_DIGITS  (MAX_DIGITS)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .head_valid          (head_valid),
      .head_entry          (head_entry),
      .pop                 (pop),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_ref_valid       (rsp_ref_valid),
      .rsp_column_index    (rsp_column_index),
      .rsp_row_index       (rsp_row_index),
      .rsp_column_absolute (rsp_column_absolute),
      .rsp_row_absolute    (rsp_row_absolute)
   );

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import crd_pkg::*;

   localparam int LETTER_LIMIT   = 3;
   localparam int DIGIT_LIMIT    = 7;
   localparam int RESULT_LATENCY = 1;
   localparam int SETTLE_GUARD   = 200000;

   localparam int unsigned COLUMN_RADIX = 26;
   localparam int unsigned ROW_RADIX    = 10;

   // ASCII codes the parser cares about
   localparam logic [7:0] CH_DOLLAR  = 8'h24;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;

   typedef enum logic [2:0] {
      LX_START,
      LX_COL_DOLLAR,
      LX_LETTERS,
      LX_ROW_DOLLAR,
      LX_DIGITS
   } lexeme_phase_type;

   typedef struct packed {
      logic                ref_valid;
      logic [COLUMN_W-1:0] column_index;
      logic [ROW_W-1:0]    row_index;
      logic                column_absolute;
      logic                row_absolute;
   } cell_ref_type;

   // One byte waiting to be sent, with an optional hand-written result
   typedef struct {
      logic [7:0]   ch;
      logic         last;
      logic         col_only;
      bit           fixed;
      cell_ref_type fixed_ref;
   } lexeme_byte_type;

   // Directed lexeme: text, or a single raw byte when raw >= 0
   typedef struct {
      string text;
      int    raw;
      bit    col_only;
      bit    fixed;
      int    ok;
      int    col;
      int    row;
      int    col_abs;
      int    row_abs;
   } directed_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [CHAR_W-1:0]    req_char_byte = '0;
   logic                 req_final_byte = 1'b0;
   logic                 req_column_only = 1'b0;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_write_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_ref_valid;
   logic [COLUMN_W-1:0]  rsp_column_index;
   logic [ROW_W-1:0]     rsp_row_index;
   logic                 rsp_column_absolute;
   logic                 rsp_row_absolute;

   cell_reference_decoder #(
      .MAX_LETTERS(LETTER_LIMIT),
      .MAX_DIGITS (DIGIT_LIMIT)
   ) DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_char_byte      (req_char_byte),
      .req_final_byte     (req_final_byte),
      .req_column_only    (req_column_only),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_ref_valid      (rsp_ref_valid),
      .rsp_column_index   (rsp_column_index),
      .rsp_row_index      (rsp_row_index),
      .rsp_column_absolute(rsp_column_absolute),
      .rsp_row_absolute   (rsp_row_absolute)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   lexeme_byte_type pending_bytes[$];
   cell_ref_type    expected_refs[$];
   lexeme_byte_type on_wire;
   int              mismatch_count = 0;
   int              result_count = 0;
   int              idle_pct = 0;
   int              stall_pct = 0;

   // Decoder image: limits and per-lexeme parse state
   logic [COLUMN_W-1:0] cfg_max_column = MAX_COLUMN_RESET;
   logic [ROW_W-1:0]    cfg_max_row    = MAX_ROW_RESET;
   lexeme_phase_type    lx_phase = LX_START;
   bit                  lx_col_only = 1'b0;
   bit                  lx_col_dollar = 1'b0;
   bit                  lx_row_dollar = 1'b0;
   int unsigned         lx_letters = 0;
   int unsigned         lx_digits = 0;
   int unsigned         lx_column = 0;
   int unsigned         lx_row = 0;
   bit                  lx_failed = 1'b0;

   directed_row_type directed_table [25] = '{
      '{"A1",         -1, 0, 1, 1, 0,     0,       0, 0},
      '{"$A$1",       -1, 0, 1, 1, 0,     0,       1, 1},
      '{"XFD1048576", -1, 0, 1, 1, 16383, 1048575, 0, 0},
      '{"XFE1",       -1, 0, 1, 0, 0,     0,       0, 0},
      '{"A1048577",   -1, 0, 1, 0, 0,     0,       0, 0},
      '{"B0",         -1, 0, 1, 0, 0,     0,       0, 0},
      '{"zz99",       -1, 0, 0, 0, 0,     0,       0, 0},
      '{"c$00042",    -1, 0, 0, 0, 0,     0,       0, 0},
      '{"1A",         -1, 0, 1, 0, 0,     0,       0, 0},
      '{"A$",         -1, 0, 1, 0, 0,     0,       0, 0},
      '{"$$A1",       -1, 0, 1, 0, 0,     0,       0, 0},
      '{"ABCD1",      -1, 0, 1, 0, 0,     0,       0, 0},
      '{"A12345678",  -1, 0, 1, 0, 0,     0,       0, 0},
      '{"A1B",        -1, 0, 1, 0, 0,     0,       0, 0},
      '{"A 1",        -1, 0, 1, 0, 0,     0,       0, 0},
      '{"$XFD",       -1, 1, 1, 1, 16383, 0,       1, 0},
      '{"a",          -1, 1, 1, 1, 0,     0,       0, 0},
      '{"A1",         -1, 1, 1, 0, 0,     0,       0, 0},
      '{"A$",         -1, 1, 1, 0, 0,     0,       0, 0},
      '{"A",          -1, 0, 1, 0, 0,     0,       0, 0},
      '{"$",          -1, 0, 1, 0, 0,     0,       0, 0},
      '{"",            0, 0, 1, 0, 0,     0,       0, 0},
      '{"",          255, 1, 1, 0, 0,     0,       0, 0},
      '{"ZZZ9999999", -1, 0, 1, 0, 0,     0,       0, 0},
      '{"@[`{/:",     -1, 0, 1, 0, 0,     0,       0, 0}
   };

   task automatic note_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got)
         note_mismatch($sformatf("result %0d %s expected %0d actual %0d",
                                 result_count, name, want, got));
   endtask

   // Advance the parse by one byte; on the last byte give the decoded reference
   task automatic decode_reference_byte(input logic [7:0] ch, input bit last,
                                        input bit col_only, output bit produced,
                                        output cell_ref_type ref_out);
      bit          upper, lower, digit, ok;
      int unsigned letter_value, tmp;
      upper = (ch >= CH_UPPER_A && ch <= CH_UPPER_Z);
      lower = (ch >= CH_LOWER_A && ch <= CH_LOWER_Z);
      digit = (ch >= CH_ZERO && ch <= CH_NINE);
      ref_out = '0;

      // mode is taken from the first byte only
      if (lx_phase == LX_START && lx_letters == 0 && !lx_failed)
         lx_col_only = col_only;

      if (!lx_failed) begin
         if (upper || lower) begin
            letter_value = (upper ? ch - CH_UPPER_A : ch - CH_LOWER_A) + 1;
            if (lx_phase > LX_LETTERS || lx_letters >= LETTER_LIMIT) begin
               lx_failed = 1'b1;
            end else begin
               lx_letters++;
               lx_phase = LX_LETTERS;
               lx_column = lx_column * COLUMN_RADIX + letter_value;
               if (lx_column > cfg_max_column) lx_failed = 1'b1;
            end
         end else if (digit) begin
            if (lx_col_only || lx_phase < LX_LETTERS || lx_digits >= DIGIT_LIMIT) begin
               lx_failed = 1'b1;
            end else begin
               lx_digits++;
               lx_phase = LX_DIGITS;
               lx_row = lx_row * ROW_RADIX + (ch - CH_ZERO);
               if (lx_row > cfg_max_row) lx_failed = 1'b1;
            end
         end else if (ch == CH_DOLLAR) begin
            if (lx_phase == LX_START) begin
               lx_col_dollar = 1'b1;
               lx_phase = LX_COL_DOLLAR;
            end else if (lx_phase == LX_LETTERS && !lx_col_only) begin
               lx_row_dollar = 1'b1;
               lx_phase = LX_ROW_DOLLAR;
            end else begin
               lx_failed = 1'b1;
            end
         end else begin
            lx_failed = 1'b1;
         end
      end

      produced = last;
      if (last) begin
         if (lx_col_only)
            ok = !lx_failed && lx_phase == LX_LETTERS;
         else
            ok = !lx_failed && lx_phase == LX_DIGITS && lx_row != 0;
         ref_out.ref_valid = ok;
         if (ok) begin
            tmp = lx_column - 1;
            ref_out.column_index = tmp[COLUMN_W-1:0];
            ref_out.column_absolute = lx_col_dollar;
            if (!lx_col_only) begin
               tmp = lx_row - 1;
               ref_out.row_index = tmp[ROW_W-1:0];
               ref_out.row_absolute = lx_row_dollar;
            end
         end
         // ready for the next lexeme
         lx_phase = LX_START;
         lx_col_only = 1'b0;
         lx_col_dollar = 1'b0;
         lx_row_dollar = 1'b0;
         lx_letters = 0;
         lx_digits = 0;
         lx_column = 0;
         lx_row = 0;
         lx_failed = 1'b0;
      end
   endtask

   // Both channels: check results, predict on each accepted byte, drive the next
   always @(posedge clock) begin : transfer_engine
      cell_ref_type want;
      cell_ref_type predicted;
      bit           produced;
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         // result transfer
         if (rsp_valid && !rsp_stall) begin
            if (expected_refs.size() == 0) begin
               note_mismatch($sformatf("unexpected result valid=%0d col=%0d row=%0d",
                                       rsp_ref_valid, rsp_column_index, rsp_row_index));
            end else begin
               want = expected_refs.pop_front();
               check_field("ref_valid", 32'(want.ref_valid), 32'(rsp_ref_valid));
               check_field("column_index", 32'(want.column_index),
                           32'(rsp_column_index));
               check_field("row_index", 32'(want.row_index), 32'(rsp_row_index));
               check_field("column_absolute", 32'(want.column_absolute),
                           32'(rsp_column_absolute));
               check_field("row_absolute", 32'(want.row_absolute),
                           32'(rsp_row_absolute));
            end
            result_count++;
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);

         // byte transfer
         if (req_valid && !req_stall) begin
            decode_reference_byte(req_char_byte, req_final_byte, req_column_only,
                                  produced, predicted);
            if (produced)
               expected_refs.insert(expected_refs.size(),
                                    on_wire.fixed ? on_wire.fixed_ref : predicted);
         end

         // a stalled byte holds; otherwise offer the next one or go idle
         if (!req_valid || !req_stall) begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= idle_pct) begin
               on_wire = pending_bytes.pop_front();
               req_valid       <= 1'b1;
               req_char_byte   <= on_wire.ch;
               req_final_byte  <= on_wire.last;
               req_column_only <= on_wire.col_only;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_W-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (index == CSR_MAX_COLUMN) cfg_max_column = data[COLUMN_W-1:0];
      else cfg_max_row = data[ROW_W-1:0];
   endtask

   // Hold the sender until every byte is in and every result is out
   task automatic settle();
      int guard;
      guard = 0;
      while ((pending_bytes.size() != 0 || req_valid || expected_refs.size() != 0) &&
             guard < SETTLE_GUARD) begin
         @(negedge clock);
         guard++;
      end
      repeat (RESULT_LATENCY + 2) @(negedge clock);
   endtask

   // Mostly well-formed references with random content, some noise and corruption
   task automatic queue_random_lexeme(output int n);
      logic [7:0]      text[$];
      logic [7:0]      base;
      bit              mode, zero_row;
      int              kind, count, pick, offset, i;
      lexeme_byte_type item;
      mode = ($urandom_range(99) < 30);
      kind = $urandom_range(99);
      if (kind < 12) begin
         count = $urandom_range(1, 6);
         for (i = 0; i < count; i++) text.insert(text.size(), 8'($urandom_range(255)));
      end else begin
         if ($urandom_range(1)) text.insert(text.size(), CH_DOLLAR);
         count = ($urandom_range(19) == 0) ? LETTER_LIMIT + 1 : $urandom_range(1, LETTER_LIMIT);
         for (i = 0; i < count; i++) begin
            base = $urandom_range(1) ? CH_LOWER_A : CH_UPPER_A;
            pick = $urandom_range(2);
            offset = (pick == 0) ? 0 : (pick == 1) ? 25 : $urandom_range(25);
            text.insert(text.size(), 8'(base + offset));
         end
         if (!mode || $urandom_range(9) == 0) begin
            if ($urandom_range(1)) text.insert(text.size(), CH_DOLLAR);
            count = ($urandom_range(19) == 0) ? DIGIT_LIMIT + 1 :
                    $urandom_range(1, DIGIT_LIMIT);
            zero_row = ($urandom_range(9) == 0);
            for (i = 0; i < count; i++)
               text.insert(text.size(),
                           zero_row ? CH_ZERO : 8'(CH_ZERO + $urandom_range(9)));
         end
         // broken sequence: one byte replaced by anything
         if (kind < 24) text[$urandom_range(text.size() - 1)] = 8'($urandom_range(255));
      end
      for (i = 0; i < text.size(); i++) begin
         item.ch        = text[i];
         item.last      = (i == text.size() - 1);
         item.col_only  = (i == 0) ? mode : 1'($urandom_range(1));
         item.fixed     = 1'b0;
         item.fixed_ref = '0;
         pending_bytes.insert(pending_bytes.size(), item);
      end
      n = text.size();
   endtask

   task automatic run_random_phase(input logic [CSR_W-1:0] col_limit,
                                   input logic [CSR_W-1:0] row_limit,
                                   input int idle, input int stall, input int budget);
      int sent, n;
      settle();
      write_register(CSR_MAX_COLUMN, col_limit);
      write_register(CSR_MAX_ROW, row_limit);
      idle_pct  = idle;
      stall_pct = stall;
      sent = 0;
      while (sent < budget) begin
         queue_random_lexeme(n);
         sent += n;
         // pause the sender halfway until all results are back
         if (sent >= budget / 2 && sent - n < budget / 2) settle();
      end
   endtask

   initial begin : main_sequence
      lexeme_byte_type item;
      int              len, i;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed lexemes at the reset limits, no idling
      foreach (directed_table[r]) begin
         len = (directed_table[r].raw >= 0) ? 1 : directed_table[r].text.len();
         for (i = 0; i < len; i++) begin
            item.ch = (directed_table[r].raw >= 0) ? directed_table[r].raw[7:0] :
                      directed_table[r].text[i];
            item.last      = (i == len - 1);
            item.col_only  = directed_table[r].col_only;
            item.fixed     = directed_table[r].fixed;
            item.fixed_ref.ref_valid       = directed_table[r].ok[0];
            item.fixed_ref.column_index    = directed_table[r].col[COLUMN_W-1:0];
            item.fixed_ref.row_index       = directed_table[r].row[ROW_W-1:0];
            item.fixed_ref.column_absolute = directed_table[r].col_abs[0];
            item.fixed_ref.row_absolute    = directed_table[r].row_abs[0];
            pending_bytes.insert(pending_bytes.size(), item);
         end
      end

      run_random_phase(18278, 9999999, 0, 0, 180);
      run_random_phase(1, 1, 68, 0, 150);
      run_random_phase(702, 1000, 0, 68, 170);
      run_random_phase(COLUMN_W'('1), ROW_W'('1), 32, 32, 170);
      run_random_phase(0, 0, 32, 32, 100);
      run_random_phase(CSR_W'($urandom_range(1, 18278)),
                       CSR_W'($urandom_range(1, 9999999)), 0, 0, 200);
      settle();

      if (expected_refs.size() != 0)
         note_mismatch($sformatf("%0d results never arrived", expected_refs.size()));
      if (mismatch_count == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

   // watchdog
   initial begin
      #5ms;
      $display("tb_top failed");
      $finish;
   end

endmodule
